### hdl/avs_pkg.sv
// ----------------------------------------------------------------------------
// avs_pkg
// Types, widths and codes shared by the agent avoidance step block.
// ----------------------------------------------------------------------------
`default_nettype none

package avs_pkg;

    localparam int POS_W  = 32;
    localparam int EXT_W  = POS_W + 1;
    localparam int SQ_W   = 2 * EXT_W;
    localparam int RAD_W  = 31;
    localparam int SPD_W  = 24;
    localparam int FB     = 30;
    localparam int F_W    = FB + 1;
    localparam int CFG_IW = 3;

    localparam logic [CFG_IW-1:0] CFG_GOAL_X  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_GOAL_Y  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_START_X = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_START_Y = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_SPEED   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_OWN_R   = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_OTHER_R = 3'd6;

    localparam logic [1:0] KIND_GOAL    = 2'd0;
    localparam logic [1:0] KIND_SIDE    = 2'd1;
    localparam logic [1:0] KIND_HELD    = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    typedef struct packed {
        logic                    func;
        logic signed [POS_W-1:0] other_x;
        logic signed [POS_W-1:0] other_y;
    } in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [1:0]              move_kind;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQ_R,
        ST_CMP,
        ST_SV_A,
        ST_SV_B,
        ST_SV_SUM,
        ST_ROOT,
        ST_DIV_X,
        ST_MUL_X,
        ST_ADD_X,
        ST_DIV_Y,
        ST_MUL_Y,
        ST_ADD_Y,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

### hdl/avs_sqrt.sv
// ----------------------------------------------------------------------------
// avs_sqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module avs_sqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [avs_pkg::SQ_W-1:0]    radicand,
    output logic      [avs_pkg::EXT_W-1:0]   root,
    output logic                             done
);

    localparam int REM_W = avs_pkg::EXT_W + 3;
    localparam int CNT_W = $clog2(avs_pkg::EXT_W);

    logic [avs_pkg::SQ_W-1:0]  n_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [avs_pkg::EXT_W-1:0] root_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign rem_sh = {rem_reg[REM_W-3:0], n_reg[avs_pkg::SQ_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(avs_pkg::EXT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg    <= {n_reg[avs_pkg::SQ_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[avs_pkg::EXT_W-2:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

### hdl/avs_div.sv
// ----------------------------------------------------------------------------
// avs_div
// Restoring divider for the unit-vector component, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module avs_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [avs_pkg::EXT_W-1:0]   mag,
    input  wire logic [avs_pkg::EXT_W-1:0]   norm,
    output logic      [avs_pkg::F_W-1:0]     quot,
    output logic                             done
);

    localparam int REM_W = avs_pkg::EXT_W + 1;
    localparam int CNT_W = $clog2(avs_pkg::F_W);

    logic [REM_W-1:0]          rem_reg;
    logic [avs_pkg::EXT_W-1:0] norm_reg;
    logic [avs_pkg::F_W-1:0]   quot_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [REM_W-1:0] rem_sh;
    logic             ge;

    assign rem_sh = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
    assign ge     = (rem_sh >= {1'b0, norm_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(avs_pkg::F_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, mag};
            norm_reg <= norm;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? rem_sh - {1'b0, norm_reg} : rem_sh;
            quot_reg <= {quot_reg[avs_pkg::F_W-2:0], ge};
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

### hdl/agent_avoidance_step.sv
// ----------------------------------------------------------------------------
// agent_avoidance_step
// Tick: squaring and compare, then the square root, then for each axis a
// division, a scale and an add, and last the output load. Zero vector: the
// position is held and the output is loaded after the square root. Restart:
// the start position is loaded. The next transaction is accepted the cycle
// after a result is loaded; a stalled output holds the block.
// Reset clears position, configuration registers and control.
// ----------------------------------------------------------------------------
`default_nettype none

module agent_avoidance_step (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire avs_pkg::in_t                      in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output avs_pkg::out_t                          out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [avs_pkg::CFG_IW-1:0]        cfg_index,
    input  wire logic [avs_pkg::POS_W-1:0]         cfg_data
);

    localparam int PW = avs_pkg::POS_W;
    localparam int EW = avs_pkg::EXT_W;
    localparam int SW = avs_pkg::SQ_W;

    avs_pkg::state_t state_reg, state_next;

    logic signed [PW-1:0]       goal_x_reg, goal_y_reg, start_x_reg, start_y_reg;
    logic [avs_pkg::SPD_W-1:0]  speed_reg;
    logic [avs_pkg::RAD_W-1:0]  own_r_reg, other_r_reg;
    logic signed [PW-1:0]       cur_x_reg, cur_y_reg;
    logic signed [EW-1:0]       dx_reg, dy_reg;
    logic [EW-1:0]              ax_reg, ay_reg;
    logic [SW-1:0]              acc_reg, mul_reg;
    logic [1:0]                 kind_reg;
    logic                       out_valid_reg;
    avs_pkg::out_t              out_reg;

    logic [EW-1:0]        mul_a, mul_b;
    logic [SW-1:0]        mul_full;
    logic                 in_acc, out_free;
    logic                 root_start, root_done, div_start, div_done;
    logic [EW-1:0]        root;
    logic [EW-1:0]        div_mag;
    logic [avs_pkg::F_W-1:0] quot;
    logic signed [EW-1:0] dx_in, dy_in, vx_goal, vy_goal, vx_n, vy_n;
    logic [EW-1:0]        r_sum;
    logic                 near;
    logic [avs_pkg::SPD_W-1:0] delta;
    logic signed [PW+1:0] sum_x, sum_y;
    logic signed [PW-1:0] sat_x, sat_y;

    function automatic logic [EW-1:0] mag_of(input logic signed [EW-1:0] v);
        mag_of = v[EW-1] ? EW'(-v) : EW'(v);
    endfunction

    function automatic logic signed [PW-1:0] sat_of(input logic signed [PW+1:0] s);
        if (s[PW+1:PW-1] == 3'b000 || s[PW+1:PW-1] == 3'b111)
            sat_of = s[PW-1:0];
        else if (s[PW+1])
            sat_of = {1'b1, {(PW-1){1'b0}}};
        else
            sat_of = {1'b0, {(PW-1){1'b1}}};
    endfunction

    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign dx_in   = {in_data.other_x[PW-1], in_data.other_x} - {cur_x_reg[PW-1], cur_x_reg};
    assign dy_in   = {in_data.other_y[PW-1], in_data.other_y} - {cur_y_reg[PW-1], cur_y_reg};
    assign vx_goal = {goal_x_reg[PW-1], goal_x_reg} - {cur_x_reg[PW-1], cur_x_reg};
    assign vy_goal = {goal_y_reg[PW-1], goal_y_reg} - {cur_y_reg[PW-1], cur_y_reg};
    assign r_sum   = EW'({1'b0, own_r_reg} + {1'b0, other_r_reg});
    assign near    = (acc_reg < mul_reg);
    assign vx_n    = near ? -dy_reg : vx_goal;
    assign vy_n    = near ? dx_reg : vy_goal;

    assign mul_full = mul_a * mul_b;
    assign delta    = mul_reg[avs_pkg::FB + avs_pkg::SPD_W - 1 : avs_pkg::FB];
    assign sum_x    = {{2{cur_x_reg[PW-1]}}, cur_x_reg}
                    + (dx_reg[EW-1] ? -(PW+2)'(delta) : (PW+2)'(delta));
    assign sum_y    = {{2{cur_y_reg[PW-1]}}, cur_y_reg}
                    + (dy_reg[EW-1] ? -(PW+2)'(delta) : (PW+2)'(delta));
    assign sat_x    = sat_of(sum_x);
    assign sat_y    = sat_of(sum_y);

    avs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (acc_reg + mul_reg),
        .root     (root),
        .done     (root_done)
    );

    avs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (div_mag),
        .norm  (root),
        .quot  (quot),
        .done  (div_done)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            avs_pkg::ST_IDLE:
            begin
                if (in_acc)
                    state_next = in_data.func ? avs_pkg::ST_FIN : avs_pkg::ST_SQ_A;
            end
            avs_pkg::ST_SQ_A:   state_next = avs_pkg::ST_SQ_B;
            avs_pkg::ST_SQ_B:   state_next = avs_pkg::ST_SQ_R;
            avs_pkg::ST_SQ_R:   state_next = avs_pkg::ST_CMP;
            avs_pkg::ST_CMP:    state_next = avs_pkg::ST_SV_A;
            avs_pkg::ST_SV_A:   state_next = avs_pkg::ST_SV_B;
            avs_pkg::ST_SV_B:   state_next = avs_pkg::ST_SV_SUM;
            avs_pkg::ST_SV_SUM: state_next = avs_pkg::ST_ROOT;
            avs_pkg::ST_ROOT:
            begin
                if (root_done)
                    state_next = (root == '0) ? avs_pkg::ST_FIN : avs_pkg::ST_DIV_X;
            end
            avs_pkg::ST_DIV_X:
            begin
                if (div_done)
                    state_next = avs_pkg::ST_MUL_X;
            end
            avs_pkg::ST_MUL_X:  state_next = avs_pkg::ST_ADD_X;
            avs_pkg::ST_ADD_X:  state_next = avs_pkg::ST_DIV_Y;
            avs_pkg::ST_DIV_Y:
            begin
                if (div_done)
                    state_next = avs_pkg::ST_MUL_Y;
            end
            avs_pkg::ST_MUL_Y:  state_next = avs_pkg::ST_ADD_Y;
            avs_pkg::ST_ADD_Y:  state_next = avs_pkg::ST_FIN;
            avs_pkg::ST_FIN:
            begin
                if (out_free)
                    state_next = avs_pkg::ST_IDLE;
            end
            default:            state_next = avs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        mul_a      = ax_reg;
        mul_b      = ax_reg;
        root_start = 1'b0;
        div_start  = 1'b0;
        div_mag    = ax_reg;
        unique case (state_reg)
            avs_pkg::ST_IDLE:   in_stall = 1'b0;
            avs_pkg::ST_SQ_B, avs_pkg::ST_SV_B:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            avs_pkg::ST_SQ_R:
            begin
                mul_a = r_sum;
                mul_b = r_sum;
            end
            avs_pkg::ST_SV_SUM: root_start = 1'b1;
            avs_pkg::ST_ROOT:   div_start = root_done && (root != '0);
            avs_pkg::ST_MUL_X, avs_pkg::ST_MUL_Y:
            begin
                mul_a = EW'(quot);
                mul_b = EW'(speed_reg);
            end
            avs_pkg::ST_ADD_X:
            begin
                div_start = 1'b1;
                div_mag   = ay_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= avs_pkg::ST_IDLE;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            speed_reg     <= '0;
            own_r_reg     <= '0;
            other_r_reg   <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    avs_pkg::CFG_GOAL_X:  goal_x_reg  <= cfg_data;
                    avs_pkg::CFG_GOAL_Y:  goal_y_reg  <= cfg_data;
                    avs_pkg::CFG_START_X: start_x_reg <= cfg_data;
                    avs_pkg::CFG_START_Y: start_y_reg <= cfg_data;
                    avs_pkg::CFG_SPEED:   speed_reg   <= cfg_data[avs_pkg::SPD_W-1:0];
                    avs_pkg::CFG_OWN_R:   own_r_reg   <= cfg_data[avs_pkg::RAD_W-1:0];
                    avs_pkg::CFG_OTHER_R: other_r_reg <= cfg_data[avs_pkg::RAD_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == avs_pkg::ST_IDLE && in_acc && in_data.func)
            begin
                cur_x_reg <= start_x_reg;
                cur_y_reg <= start_y_reg;
            end
            if (state_reg == avs_pkg::ST_ADD_X)
                cur_x_reg <= sat_x;
            if (state_reg == avs_pkg::ST_ADD_Y)
                cur_y_reg <= sat_y;
            if (state_reg == avs_pkg::ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_full;
        unique case (state_reg)
            avs_pkg::ST_IDLE:
            begin
                dx_reg   <= dx_in;
                dy_reg   <= dy_in;
                ax_reg   <= mag_of(dx_in);
                ay_reg   <= mag_of(dy_in);
                kind_reg <= avs_pkg::KIND_RESTART;
            end
            avs_pkg::ST_SQ_B, avs_pkg::ST_SV_B:
                acc_reg <= mul_reg;
            avs_pkg::ST_SQ_R:
                acc_reg <= acc_reg + mul_reg;
            avs_pkg::ST_CMP:
            begin
                dx_reg   <= vx_n;
                dy_reg   <= vy_n;
                ax_reg   <= mag_of(vx_n);
                ay_reg   <= mag_of(vy_n);
                kind_reg <= near ? avs_pkg::KIND_SIDE : avs_pkg::KIND_GOAL;
            end
            avs_pkg::ST_ROOT:
            begin
                if (root_done && root == '0)
                    kind_reg <= avs_pkg::KIND_HELD;
            end
            avs_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_reg.pos_x     <= cur_x_reg;
                    out_reg.pos_y     <= cur_y_reg;
                    out_reg.move_kind <= kind_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire
